// ----- rtl/core/sct_pkg.sv -----
// Package for the saturated consensus trajectory block.
// Holds the request and response payload types, the controller command and
// status structs, register indexes and fixed widths. No dependencies.
package sct_pkg;

   // Fixed field widths.
   localparam int AGENT_W   = 3;
   localparam int AXIS_W    = 2;
   localparam int STEP_W    = 6;
   localparam int COORD_W   = 32;
   localparam int CNT_W     = 4;
   localparam int ACC_W     = 36;
   localparam int DIV_BITS  = 51;
   localparam int DIV_CNT_W = 6;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ADJACENCY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGENT_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACKED_AGENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT   = 3'd5;

   // Register reset values.
   localparam logic [63:0] RST_ADJACENCY     = 64'd0;
   localparam logic [3:0]  RST_AGENT_COUNT   = 4'd2;
   localparam logic [2:0]  RST_TRACKED_AGENT = 3'd0;
   localparam logic [5:0]  RST_STEP_COUNT    = 6'd1;
   localparam logic [15:0] RST_STEP_TIME     = 16'd655;
   localparam logic [30:0] RST_SPEED_LIMIT   = 31'd65536;

   // One load request.
   typedef struct packed {
      logic [AGENT_W-1:0]        agent;
      logic [AXIS_W-1:0]         axis;
      logic signed [COORD_W-1:0] position;
      logic                      load_done;
   } req_type;

   // One trajectory sample.
   typedef struct packed {
      logic [STEP_W-1:0]         step_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic                      run_last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               load;
      logic               lap_en;
      logic               lap_clr;
      logic               max_clr;
      logic               max_upd;
      logic               div_start;
      logic               div_step;
      logic               gain_ld;
      logic               mul1;
      logic               vel_wr;
      logic               pos_rd;
      logic               pos_wr;
      logic               em_rd;
      logic               em_fire;
      logic [AGENT_W-1:0] i;
      logic [AGENT_W-1:0] j;
      logic [AXIS_W-1:0]  d;
      logic [STEP_W-1:0]  step_idx;
      logic               last;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } ctl_stat_type;

endpackage

// ----- rtl/core/sct_ctrl.sv -----
// Controller state machine of the saturated consensus trajectory block.
// Sequences loads, the gain pass, the divider and each step's passes.
// Depends on sct_pkg.
module sct_ctrl #(
   parameter int MAX_AGENTS = 8,
   parameter int AXES       = 3,
   parameter int MAX_STEPS  = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_load_done,
   input  logic [3:0]           agent_count,
   input  logic [5:0]           step_count,
   input  sct_pkg::ctl_stat_type stat,
   output logic                 req_stall,
   output sct_pkg::ctl_cmd_type cmd
);
   import sct_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_LAP   = 4'd2;
   localparam logic [3:0] S_LAPW  = 4'd3;
   localparam logic [3:0] S_MAXU  = 4'd4;
   localparam logic [3:0] S_DIVI  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_GAIN  = 4'd7;
   localparam logic [3:0] S_EMR   = 4'd8;
   localparam logic [3:0] S_EMF   = 4'd9;
   localparam logic [3:0] S_MUL1  = 4'd10;
   localparam logic [3:0] S_MUL2  = 4'd11;
   localparam logic [3:0] S_POSR  = 4'd12;
   localparam logic [3:0] S_POSW  = 4'd13;

   localparam logic [AXIS_W-1:0] LAST_D  = AXIS_W'(AXES - 1);
   localparam logic [AXIS_W-1:0] LAST_EM = AXIS_W'(2);

   logic [3:0]           state_ff, state_in;
   logic [AGENT_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [AXIS_W-1:0]    d_ff, d_in;
   logic                 pass_ff, pass_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [CNT_W-1:0]  active_cnt;
   logic [STEP_W-1:0] n_steps;
   logic              row_last;

   // Clamp the agent and step counts into their legal ranges.
   always_comb begin
      if (agent_count < CNT_W'(2)) begin
         active_cnt = CNT_W'(2);
      end else if (agent_count > CNT_W'(MAX_AGENTS)) begin
         active_cnt = CNT_W'(MAX_AGENTS);
      end else begin
         active_cnt = agent_count;
      end
      n_steps  = (step_count > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : step_count;
      row_last = ({1'b0, i_ff} == active_cnt - CNT_W'(1)) && (d_ff == LAST_D);
   end

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      d_in     = d_ff;
      pass_in  = pass_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.i    = i_ff;
      cmd.j    = j_ff;
      cmd.d    = d_ff;
      cmd.step_idx = step_ff;
      cmd.last     = (step_ff == n_steps);
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid && req_load_done) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.max_clr = 1'b1;
            i_in     = '0;
            j_in     = '0;
            d_in     = '0;
            pass_in  = 1'b0;
            state_in = S_LAP;
         end
         S_LAP: begin
            cmd.lap_en  = 1'b1;
            cmd.lap_clr = (j_ff == '0);
            if ({1'b0, j_ff} == active_cnt - CNT_W'(1)) begin
               j_in     = '0;
               state_in = S_LAPW;
            end else begin
               j_in = j_ff + AGENT_W'(1);
            end
         end
         S_LAPW: begin
            state_in = pass_ff ? S_MUL1 : S_MAXU;
         end
         S_MAXU: begin
            cmd.max_upd = 1'b1;
            if (row_last) begin
               state_in = S_DIVI;
            end else begin
               state_in = S_LAP;
            end
         end
         S_DIVI: begin
            cmd.div_start = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.gain_ld = 1'b1;
            step_in  = '0;
            d_in     = '0;
            state_in = S_EMR;
         end
         S_EMR: begin
            // Hold off the first read while the output register is full.
            if (!(d_ff == '0 && stat.rsp_busy)) begin
               cmd.em_rd = 1'b1;
               if (d_ff == LAST_EM) begin
                  d_in     = '0;
                  state_in = S_EMF;
               end else begin
                  d_in = d_ff + AXIS_W'(1);
               end
            end
         end
         S_EMF: begin
            cmd.em_fire = 1'b1;
            if (step_ff == n_steps) begin
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               pass_in  = 1'b1;
               i_in     = '0;
               j_in     = '0;
               d_in     = '0;
               state_in = S_LAP;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.vel_wr = 1'b1;
            if (row_last) begin
               state_in = S_POSR;
            end else begin
               state_in = S_LAP;
            end
         end
         S_POSR: begin
            cmd.pos_rd = 1'b1;
            state_in   = S_POSW;
         end
         S_POSW: begin
            cmd.pos_wr = 1'b1;
            if (row_last) begin
               state_in = S_EMR;
            end else begin
               state_in = S_POSR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Row advance shared by the gain, velocity and position passes.
      if (cmd.max_upd || cmd.vel_wr || cmd.pos_wr) begin
         if (row_last) begin
            i_in = '0;
            d_in = '0;
         end else if (d_ff == LAST_D) begin
            d_in = '0;
            i_in = i_ff + AGENT_W'(1);
         end else begin
            d_in = d_ff + AXIS_W'(1);
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         d_ff     <= '0;
         pass_ff  <= 1'b0;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         d_ff     <= d_in;
         pass_ff  <= pass_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/sct_datapath.sv -----
// Datapath of the saturated consensus trajectory block: position and
// velocity memories, Laplacian accumulator, gain divider, velocity and
// position arithmetic, output register. Depends on sct_pkg.
module sct_datapath #(
   parameter int MAX_AGENTS = 8,
   parameter int AXES       = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sct_pkg::ctl_cmd_type  cmd,
   input  sct_pkg::req_type      req_data,
   input  logic [63:0]           adjacency,
   input  logic [2:0]            tracked_agent,
   input  logic [15:0]           step_time,
   input  logic [30:0]           speed_limit,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output sct_pkg::rsp_type      rsp_data,
   output sct_pkg::ctl_stat_type stat
);
   import sct_pkg::*;

   localparam int SLOTS  = MAX_AGENTS * AXES;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [AGENT_W-1:0] ag,
                                                 input logic [AXIS_W-1:0] ax);
      slot_of = SLOT_W'(int'(ag) * AXES + int'(ax));
   endfunction

   logic [COORD_W-1:0] pos_mem [SLOTS];
   logic [COORD_W-1:0] vel_mem [SLOTS];

   logic [COORD_W-1:0] rd_a_ff, rd_b_ff, vel_rd_ff;
   logic [SLOT_W-1:0]  addr_a, addr_b, addr_row;
   logic               pos_we;
   logic [SLOT_W-1:0]  pos_waddr;
   logic [COORD_W-1:0] pos_wdata;

   logic               lap_v_ff, lap_clr_ff, lap_bit_ff;
   logic               em_v_ff, em_ok_ff;
   logic [AXIS_W-1:0]  em_ax_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, diff;
   logic [ACC_W-1:0]   mag;
   logic [ACC_W-1:0]   max_ff;

   logic [DIV_BITS-1:0] num_ff, quo_ff;
   logic [ACC_W-1:0]    rem_ff, rem_sh;
   logic [34:0]         lim_x10;

   logic [31:0]        gain_ff;
   logic [63:0]        prod_lo_ff;
   logic [3:0]         mag_hi_ff;
   logic               neg_ff;
   logic [35:0]        prod_hi;
   logic [67:0]        prod_full;
   logic [51:0]        vm_wide;
   logic [30:0]        vm;
   logic [COORD_W-1:0] vel_new;

   logic [COORD_W-1:0] vabs;
   logic [47:0]        dprod;
   logic [33:0]        dlt, x_new;
   logic [COORD_W-1:0] x_sat;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               load_ok;

   // Read and write addresses.
   always_comb begin
      addr_row  = slot_of(cmd.i, cmd.d);
      addr_a    = cmd.em_rd ? slot_of(tracked_agent, cmd.d) : addr_row;
      addr_b    = slot_of(cmd.j, cmd.d);
      load_ok   = (int'(req_data.agent) < MAX_AGENTS) && (int'(req_data.axis) < AXES);
      pos_we    = (cmd.load && load_ok) || cmd.pos_wr;
      pos_waddr = cmd.pos_wr ? addr_row : slot_of(req_data.agent, req_data.axis);
      pos_wdata = cmd.pos_wr ? x_sat : req_data.position;
   end

   // Position and velocity memories with registered reads.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      if (cmd.vel_wr) begin
         vel_mem[addr_row] <= vel_new;
      end
      rd_a_ff   <= pos_mem[addr_a];
      rd_b_ff   <= pos_mem[addr_b];
      vel_rd_ff <= vel_mem[addr_row];
   end

   // Laplacian row accumulator, one neighbor a cycle.
   always_comb begin
      diff = {{(ACC_W-COORD_W){rd_a_ff[COORD_W-1]}}, rd_a_ff}
           - {{(ACC_W-COORD_W){rd_b_ff[COORD_W-1]}}, rd_b_ff};
      acc_in = lap_clr_ff ? '0 : acc_ff;
      if (lap_bit_ff) begin
         acc_in = acc_in + diff;
      end
      mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   end

   // Gain divider step: numerator is ten times the limit in Q16.16.
   always_comb begin
      lim_x10 = {1'b0, speed_limit, 3'b000} + {3'b000, speed_limit, 1'b0};
      rem_sh  = {rem_ff[ACC_W-2:0], num_ff[DIV_BITS-1]};
   end

   // Velocity magnitude: full product of magnitude and gain, then clamp.
   always_comb begin
      prod_hi   = 36'(mag_hi_ff) * 36'(gain_ff);
      prod_full = {4'b0000, prod_lo_ff} + {prod_hi, 32'd0};
      vm_wide   = prod_full[67:16];
      vm        = (vm_wide > {21'd0, speed_limit}) ? speed_limit : vm_wide[30:0];
      vel_new   = neg_ff ? (32'd0 - {1'b0, vm}) : {1'b0, vm};
   end

   // Position update, rounding the step toward zero and saturating.
   always_comb begin
      vabs  = vel_rd_ff[COORD_W-1] ? (32'd0 - vel_rd_ff) : vel_rd_ff;
      dprod = 48'(step_time) * 48'(vabs);
      dlt   = {2'b00, dprod[47:16]};
      x_new = {{2{rd_a_ff[COORD_W-1]}}, rd_a_ff}
            + (vel_rd_ff[COORD_W-1] ? (34'd0 - dlt) : dlt);
      if (!x_new[33] && x_new[32:31] != 2'b00) begin
         x_sat = 32'h7FFF_FFFF;
      end else if (x_new[33] && x_new[32:31] != 2'b11) begin
         x_sat = 32'h8000_0000;
      end else begin
         x_sat = x_new[31:0];
      end
   end

   // Control pipeline flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         lap_v_ff     <= 1'b0;
         lap_clr_ff   <= 1'b0;
         lap_bit_ff   <= 1'b0;
         em_v_ff      <= 1'b0;
         em_ok_ff     <= 1'b0;
         em_ax_ff     <= '0;
         gain_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lap_v_ff   <= cmd.lap_en;
         lap_clr_ff <= cmd.lap_en && cmd.lap_clr;
         lap_bit_ff <= cmd.lap_en && adjacency[{cmd.i, cmd.j}];
         em_v_ff    <= cmd.em_rd;
         em_ok_ff   <= (int'(cmd.d) < AXES) && (int'(tracked_agent) < MAX_AGENTS);
         em_ax_ff   <= cmd.d;
         if (cmd.gain_ld) begin
            if (max_ff == '0) begin
               gain_ff <= '0;
            end else if (quo_ff[DIV_BITS-1:32] != '0) begin
               gain_ff <= 32'hFFFF_FFFF;
            end else begin
               gain_ff <= quo_ff[31:0];
            end
         end
         if (cmd.em_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (lap_v_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.max_clr) begin
         max_ff <= '0;
      end else if (cmd.max_upd && mag > max_ff) begin
         max_ff <= mag;
      end
      if (cmd.div_start) begin
         num_ff <= {lim_x10, 16'd0};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[DIV_BITS-2:0], 1'b0};
         if (rem_sh >= max_ff) begin
            rem_ff <= rem_sh - max_ff;
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
      if (cmd.mul1) begin
         prod_lo_ff <= 64'(mag[31:0]) * 64'(gain_ff);
         mag_hi_ff  <= mag[35:32];
         neg_ff     <= !acc_ff[ACC_W-1] && (acc_ff != '0);
      end
      if (em_v_ff) begin
         case (em_ax_ff)
            2'd0:    rsp_ff.coord_x <= em_ok_ff ? rd_a_ff : '0;
            2'd1:    rsp_ff.coord_y <= em_ok_ff ? rd_a_ff : '0;
            default: rsp_ff.coord_z <= em_ok_ff ? rd_a_ff : '0;
         endcase
      end
      if (cmd.em_fire) begin
         rsp_ff.step_index <= cmd.step_idx;
         rsp_ff.run_last   <= cmd.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;

endmodule

// ----- rtl/core/saturated_consensus_trajectory.sv -----
// Saturated consensus trajectory generator: top level.
// Holds the configuration registers and joins sct_ctrl and sct_datapath.
// Depends on sct_pkg.
//
// Use: write the configuration through csr_we/csr_index/csr_wdata while
// the block is idle. Each request on the req_ channel loads one start
// coordinate of one agent and axis, unless the axis is out of range.
// A request with load_done set is also stored and starts a run; req_stall
// stays high until the run ends. A run produces step_count+1 responses on
// the rsp_ channel, one for the start and one per step, the final one with
// run_last set. The gain pass finds the largest Laplacian magnitude and
// the serial gain divider forms the gain from it. Each step then has a
// velocity pass that walks one neighbor a cycle through the position
// memory, a position update pass and the read of the tracked agent's
// three coordinates.
// The response sits in an output register; if the receiver stalls, the
// next step's computation goes ahead and waits only before its own
// output. Synchronous reset returns to idle, clears the gain and restores
// register defaults; stored positions are undefined until loaded.
module saturated_consensus_trajectory #(
   parameter int MAX_AGENTS = 8,
   parameter int AXES       = 3,
   parameter int MAX_STEPS  = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sct_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sct_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [sct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sct_pkg::*;

   logic [63:0] adjacency_ff;
   logic [3:0]  agent_count_ff;
   logic [2:0]  tracked_agent_ff;
   logic [5:0]  step_count_ff;
   logic [15:0] step_time_ff;
   logic [30:0] speed_limit_ff;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         adjacency_ff     <= RST_ADJACENCY;
         agent_count_ff   <= RST_AGENT_COUNT;
         tracked_agent_ff <= RST_TRACKED_AGENT;
         step_count_ff    <= RST_STEP_COUNT;
         step_time_ff     <= RST_STEP_TIME;
         speed_limit_ff   <= RST_SPEED_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADJACENCY:     adjacency_ff     <= csr_wdata;
            CSR_AGENT_COUNT:   agent_count_ff   <= csr_wdata[3:0];
            CSR_TRACKED_AGENT: tracked_agent_ff <= csr_wdata[2:0];
            CSR_STEP_COUNT:    step_count_ff    <= csr_wdata[5:0];
            CSR_STEP_TIME:     step_time_ff     <= csr_wdata[15:0];
            CSR_SPEED_LIMIT:   speed_limit_ff   <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   // Controller.
   sct_ctrl #(
      .MAX_AGENTS (MAX_AGENTS),
      .AXES       (AXES),
      .MAX_STEPS  (MAX_STEPS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_load_done (req_data.load_done),
      .agent_count   (agent_count_ff),
      .step_count    (step_count_ff),
      .stat          (stat),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   // Datapath.
   sct_datapath #(
      .MAX_AGENTS (MAX_AGENTS),
      .AXES       (AXES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data      (req_data),
      .adjacency     (adjacency_ff),
      .tracked_agent (tracked_agent_ff),
      .step_time     (step_time_ff),
      .speed_limit   (speed_limit_ff),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .stat          (stat)
   );

endmodule

// ----- rtl/core/sct_checker.sv -----
// Port-level checker for the saturated consensus trajectory block, with
// the bind that attaches it to the top level. Depends on sct_pkg.
module sct_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sct_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sct_pkg::rsp_type rsp_data
);
   import sct_pkg::*;

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // A final load starts a run, so no request is taken next cycle.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.load_done |=> req_stall)
      else $error("request accepted right after a final load");

   // Until the last response of a run, the run is still going.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_last |=> req_stall)
      else $error("request accepted in the middle of a run");

endmodule

bind saturated_consensus_trajectory sct_checker u_sct_checker (.*);

// ----- tb/tb.sv -----
// Testbench for the saturated consensus trajectory block.
// Holds its own consensus predictor and checks every sample against it.
// Depends on sct_pkg and saturated_consensus_trajectory.
`timescale 1ns / 1ps

module tb;
   import sct_pkg::*;

   localparam int AGENT_SLOTS = 8;
   localparam int N_AXES   = 3;
   localparam int N_SLOTS  = AGENT_SLOTS * N_AXES;
   localparam int TOTAL_REQUESTS = 470;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor state: shadow registers and positions.
   logic [63:0]        sh_adjacency;
   logic [3:0]         sh_agent_count;
   logic [2:0]         sh_tracked;
   logic [5:0]         sh_step_count;
   logic [15:0]        sh_step_time;
   logic [30:0]        sh_speed_limit;
   logic signed [31:0] sh_pos[N_SLOTS];

   rsp_type exp_samples[$];
   int      err_count;
   int      sent_requests;
   int      run_count;
   int      sample_count;
   int      send_idle_pct;
   int      stall_pct;

   saturated_consensus_trajectory u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Safety net in case the block hangs.
   initial begin
      #1_000_000_000;
      $display("saturated_consensus_trajectory: mismatch");
      $finish;
   end

   function automatic longint unsigned mag(longint signed v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   // Laplacian row for one agent and axis, summed exactly.
   function automatic longint signed laplacian(int i, int d, int n);
      longint signed acc;
      acc = 0;
      for (int j = 0; j < n; j++)
         if (sh_adjacency[i*8+j])
            acc += longint'(sh_pos[i*N_AXES+d]) - longint'(sh_pos[j*N_AXES+d]);
      return acc;
   endfunction

   function automatic rsp_type tracked_sample(int s, bit last);
      rsp_type e;
      e.step_index = s[5:0];
      e.coord_x    = sh_pos[sh_tracked*N_AXES+0];
      e.coord_y    = sh_pos[sh_tracked*N_AXES+1];
      e.coord_z    = sh_pos[sh_tracked*N_AXES+2];
      e.run_last   = last;
      return e;
   endfunction

   // Store the coordinate and, on the final load, integrate the whole run.
   task automatic predict_trajectory(req_type r);
      int                  n, steps;
      longint unsigned     maxabs, m, lim, g, q, vm, dlt;
      longint signed       lv, x;
      logic [127:0]        prod;
      logic signed [31:0]  vel[N_SLOTS];
      if (r.axis < N_AXES) sh_pos[r.agent*N_AXES+r.axis] = r.position;
      if (!r.load_done) return;
      n = sh_agent_count < 2 ? 2 : (sh_agent_count > AGENT_SLOTS ? AGENT_SLOTS : sh_agent_count);
      steps = sh_step_count;
      lim = sh_speed_limit;
      maxabs = 0;
      for (int i = 0; i < n; i++)
         for (int d = 0; d < N_AXES; d++) begin
            m = mag(laplacian(i, d, n));
            if (m > maxabs) maxabs = m;
         end
      if (maxabs == 0) begin
         g = 0;
      end else begin
         q = ((64'd10 * lim) << 16) / maxabs;
         g = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
      end
      run_count++;
      exp_samples.push_back(tracked_sample(0, steps == 0));
      for (int s = 1; s <= steps; s++) begin
         // Velocities all come from the positions of the previous step.
         for (int i = 0; i < n; i++)
            for (int d = 0; d < N_AXES; d++) begin
               lv = laplacian(i, d, n);
               m = mag(lv);
               if (g == 0 || m == 0) begin
                  vm = 0;
               end else begin
                  prod = {64'd0, m} * {64'd0, g};
                  if (prod[127:64] != 0) vm = lim;
                  else vm = prod[63:16];
                  if (vm > lim) vm = lim;
               end
               vel[i*N_AXES+d] = (lv > 0) ? -$signed(vm[31:0]) : $signed(vm[31:0]);
            end
         for (int i = 0; i < n; i++)
            for (int d = 0; d < N_AXES; d++) begin
               dlt = (longint'(sh_step_time) * mag(vel[i*N_AXES+d])) >> 16;
               x = longint'(sh_pos[i*N_AXES+d]) +
                   ((vel[i*N_AXES+d] < 0) ? -longint'(dlt) : longint'(dlt));
               if (x > 64'sd2147483647) x = 64'sd2147483647;
               if (x < -64'sd2147483648) x = -64'sd2147483648;
               sh_pos[i*N_AXES+d] = x[31:0];
            end
         exp_samples.push_back(tracked_sample(s, s == steps));
      end
   endtask

   // Send one request, with a random idle gap first.
   task automatic send_request(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'({$urandom, $urandom});
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predict_trajectory(r);
      sent_requests++;
   endtask

   task automatic load_slot(int ag, int ax, logic [31:0] p, bit done);
      req_type r;
      r.agent = ag[2:0];
      r.axis = ax[1:0];
      r.position = p;
      r.load_done = done;
      send_request(r);
   endtask

   // Wait for the run to drain and the block to settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (exp_samples.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ADJACENCY:     sh_adjacency = val;
         CSR_AGENT_COUNT:   sh_agent_count = val[3:0];
         CSR_TRACKED_AGENT: sh_tracked = val[2:0];
         CSR_STEP_COUNT:    sh_step_count = val[5:0];
         CSR_STEP_TIME:     sh_step_time = val[15:0];
         CSR_SPEED_LIMIT:   sh_speed_limit = val[30:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_position();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         2: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   // Receiver stalls at random.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare each accepted sample with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_type e;
         sample_count++;
         if (exp_samples.size() == 0) begin
            $error("sample with no prediction waiting: %p", rsp_data);
            err_count++;
         end else begin
            e = exp_samples.pop_front();
            if (rsp_data.step_index !== e.step_index) begin
               $error("step_index expected %0d got %0d", e.step_index, rsp_data.step_index);
               err_count++;
            end
            if (rsp_data.coord_x !== e.coord_x) begin
               $error("coord_x expected %h got %h", e.coord_x, rsp_data.coord_x);
               err_count++;
            end
            if (rsp_data.coord_y !== e.coord_y) begin
               $error("coord_y expected %h got %h", e.coord_y, rsp_data.coord_y);
               err_count++;
            end
            if (rsp_data.coord_z !== e.coord_z) begin
               $error("coord_z expected %h got %h", e.coord_z, rsp_data.coord_z);
               err_count++;
            end
            if (rsp_data.run_last !== e.run_last) begin
               $error("run_last expected %0d got %0d", e.run_last, rsp_data.run_last);
               err_count++;
            end
         end
      end
   end

   // Reset defaults: load every slot once, then one run on reset settings.
   task automatic test_reset_defaults();
      for (int s = 0; s < N_SLOTS; s++)
         load_slot(s / N_AXES, s % N_AXES, rand_position(), 1'b0);
      load_slot(0, 0, 32'h0001_0000, 1'b1);
      wait_idle();
   endtask

   // Extremes of fields and registers and the special cases.
   task automatic test_directed_cases();
      // Full mesh at eight agents (count above range), maximum limit and step.
      write_reg(CSR_ADJACENCY, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_AGENT_COUNT, 64'd15);
      write_reg(CSR_SPEED_LIMIT, 64'h7FFF_FFFF);
      write_reg(CSR_STEP_TIME, 64'hFFFF);
      write_reg(CSR_STEP_COUNT, 64'd3);
      write_reg(CSR_TRACKED_AGENT, 64'd7);
      load_slot(0, 0, 32'h7FFF_FFFF, 1'b0);
      load_slot(7, 2, 32'h8000_0000, 1'b0);
      load_slot(3, 1, 32'h0000_0000, 1'b1);
      wait_idle();
      // Zero step count gives only the start sample.
      write_reg(CSR_STEP_COUNT, 64'd0);
      load_slot(5, 1, 32'hFFFF_FFFF, 1'b1);
      wait_idle();
      // Count below range, inactive tracked agent, unused axis with final flag.
      write_reg(CSR_AGENT_COUNT, 64'd0);
      write_reg(CSR_TRACKED_AGENT, 64'd4);
      write_reg(CSR_STEP_COUNT, 64'd63);
      write_reg(CSR_ADJACENCY, 64'h0000_0000_0000_0102);
      load_slot(1, 3, 32'h1234_5678, 1'b1);
      wait_idle();
      // Zero limit and zero step time keep everyone still.
      write_reg(CSR_SPEED_LIMIT, 64'd0);
      write_reg(CSR_STEP_COUNT, 64'd2);
      load_slot(0, 1, 32'h0050_0000, 1'b1);
      wait_idle();
      write_reg(CSR_SPEED_LIMIT, 64'h0001_0000);
      write_reg(CSR_STEP_TIME, 64'd0);
      load_slot(2, 2, 32'hFFF0_0000, 1'b1);
      wait_idle();
      // Self loops only, so every Laplacian row and the gain are zero.
      write_reg(CSR_STEP_TIME, 64'd655);
      write_reg(CSR_AGENT_COUNT, 64'd8);
      write_reg(CSR_ADJACENCY, 64'h8040_2010_0804_0201);
      load_slot(6, 0, 32'h0001_0000, 1'b1);
      wait_idle();
   endtask

   // Random runs: usually new settings, up to six loads, then the final load.
   task automatic test_random_runs(int idle_pct, int stl_pct, int quota);
      int stop_at;
      send_idle_pct = idle_pct;
      stall_pct = stl_pct;
      stop_at = sent_requests + quota;
      while (sent_requests < stop_at) begin
         int loads;
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(2))
               0: write_reg(CSR_ADJACENCY, {$urandom, $urandom});
               1: write_reg(CSR_ADJACENCY, {$urandom, $urandom} & {$urandom, $urandom});
               default: write_reg(CSR_ADJACENCY, 64'hFFFF_FFFF_FFFF_FFFF);
            endcase
            write_reg(CSR_AGENT_COUNT, {$urandom, $urandom});
            write_reg(CSR_TRACKED_AGENT, {$urandom, $urandom});
            write_reg(CSR_STEP_COUNT, ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                                              : $urandom_range(8));
            write_reg(CSR_STEP_TIME, ($urandom_range(1)) ? {$urandom, $urandom}
                                                         : $urandom_range(4000));
            write_reg(CSR_SPEED_LIMIT, ($urandom_range(1)) ? {$urandom, $urandom}
                                                           : $urandom_range(32'h0008_0000));
         end
         loads = $urandom_range(6);
         for (int k = 0; k < loads; k++)
            load_slot($urandom_range(7), ($urandom_range(9) == 0) ? 3 : $urandom_range(2),
                      rand_position(), 1'b0);
         load_slot($urandom_range(7), $urandom_range(3), rand_position(), 1'b1);
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_ADJACENCY;
      csr_wdata = '0;
      err_count = 0;
      sent_requests = 0;
      run_count = 0;
      sample_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      sh_adjacency = RST_ADJACENCY;
      sh_agent_count = RST_AGENT_COUNT;
      sh_tracked = RST_TRACKED_AGENT;
      sh_step_count = RST_STEP_COUNT;
      sh_step_time = RST_STEP_TIME;
      sh_speed_limit = RST_SPEED_LIMIT;
      foreach (sh_pos[s]) sh_pos[s] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_random_runs(0, 0, 110);
      test_random_runs(69, 0, 110);
      test_random_runs(0, 69, 110);
      test_random_runs(13, 13, TOTAL_REQUESTS - sent_requests);

      if (exp_samples.size() != 0) begin
         $error("%0d predicted samples never arrived", exp_samples.size());
         err_count++;
      end
      $display("Sent %0d load requests over %0d runs; checked %0d trajectory samples.",
               sent_requests, run_count, sample_count);
      if (err_count == 0)
         $display("saturated_consensus_trajectory: match");
      else
         $display("saturated_consensus_trajectory: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sct_pkg.sv
rtl/core/sct_ctrl.sv
rtl/core/sct_datapath.sv
rtl/core/saturated_consensus_trajectory.sv
rtl/core/sct_checker.sv
tb/tb.sv
